/* rtl/srs_pkg.sv */
// Shared types and constants of the selective-repeat sender.
// Used by every module of the block; depends on nothing else.
package srs_pkg;

   // Operation codes carried by a request.
   localparam logic OP_TICK = 1'b0;
   localparam logic OP_ACK  = 1'b1;

   // Configuration register map: one register, selected by address bit 2.
   localparam int   CSR_ADDR_BITS  = 3;
   localparam logic REG_TIMEOUT    = 1'b0;
   localparam logic [7:0] TIMEOUT_RESET = 8'd4;

   // Depth of the command queue between front and back.
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic        operation;
      logic [15:0] ack_number;
   } req_type;

   typedef struct packed {
      logic [15:0] send_number;
      logic        is_resend;
      logic        last_of_run;
   } rsp_type;

   typedef enum logic {
      CMD_TICK,
      CMD_ACK
   } cmd_kind_type;

   // Classified command handed from the front to the back.
   typedef struct packed {
      cmd_kind_type kind;
      logic [15:0]  ack;
   } cmd_type;

   // Queue status seen by its producer and consumer.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_stat_type;

endpackage

/* rtl/srs_front.sv */
// Request front end: takes requests, decodes the operation into a command.
// Depends on srs_pkg; feeds srs_queue.
module srs_front import srs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  req_type        req_data,
   input  queue_stat_type q_stat,
   output logic           q_push,
   output cmd_type        q_wdata
);

   logic    hold_valid_ff, hold_valid_in;
   cmd_type hold_ff, hold_in;
   logic    accept;

   // Stall only while a decoded command is waiting on a full queue.
   assign req_stall = hold_valid_ff & q_stat.full;
   assign accept    = req_valid & ~req_stall;
   assign q_push    = hold_valid_ff & ~q_stat.full;
   assign q_wdata   = hold_ff;

   // Decode the operation code and capture the acknowledged number.
   always_comb begin
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      if (q_push) begin
         hold_valid_in = 1'b0;
      end
      if (accept) begin
         hold_valid_in = 1'b1;
         hold_in.kind  = (req_data.operation == OP_ACK) ? CMD_ACK : CMD_TICK;
         hold_in.ack   = req_data.ack_number;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_ff <= hold_in;
   end

endmodule

/* rtl/srs_queue.sv */
// Short command queue that decouples the front end from the back end.
// Depends on srs_pkg for the command type and depth.
module srs_queue import srs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  cmd_type        wdata,
   input  logic           pop,
   output cmd_type        rdata,
   output queue_stat_type stat
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign stat.full  = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign rdata      = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates; the pointers wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

/* rtl/srs_back.sv */
// Back end: window state, deadline memory, timeout scan and window slide.
// Depends on srs_pkg; pops commands from srs_queue and drives the result channel.
module srs_back import srs_pkg::*; #(
   parameter int WINDOW    = 8,
   parameter int SEQ_BITS  = 16,
   parameter int TIME_BITS = 32
) (
   input  logic           clock,
   input  logic           reset,
   input  logic [7:0]     timeout,
   input  queue_stat_type q_stat,
   input  cmd_type        q_rdata,
   output logic           q_pop,
   output logic           rsp_valid,
   input  logic           rsp_stall,
   output rsp_type        rsp_data
);

   localparam int SLOTS     = 2 * WINDOW;
   localparam int SLOT_BITS = $clog2(SLOTS);
   localparam int CNT_BITS  = $clog2(WINDOW + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SLIDE,
      ST_FINISH
   } state_type;

   // Ring position of window entry k: one add and one conditional subtract.
   function automatic logic [SLOT_BITS-1:0] slot_of(input logic [SLOT_BITS-1:0] head,
                                                    input logic [CNT_BITS-1:0]  k);
      logic [SLOT_BITS:0] sum;
      sum = {1'b0, head} + (SLOT_BITS+1)'(k);
      if (sum >= (SLOT_BITS+1)'(SLOTS)) begin
         sum = sum - (SLOT_BITS+1)'(SLOTS);
      end
      return sum[SLOT_BITS-1:0];
   endfunction

   state_type            state_ff, state_in;
   logic [CNT_BITS-1:0]  k_ff, k_in;
   logic [SLOTS-1:0]     acked_ff, acked_in;
   logic [SLOTS-1:0]     dl_valid_ff, dl_valid_in;
   logic [SEQ_BITS-1:0]  base_ff, base_in;
   logic [SLOT_BITS-1:0] head_ff, head_in;
   logic [TIME_BITS-1:0] tick_ff, tick_in;
   logic                 pend_valid_ff, pend_valid_in;
   rsp_type              pend_ff, pend_in;
   logic                 out_valid_ff, out_valid_in;
   rsp_type              out_ff, out_in;
   logic                 rd_vld_ff, rd_vld_in;

   // Deadline memory with registered read data.
   logic [TIME_BITS-1:0] dl_mem_ff [SLOTS];
   logic [TIME_BITS-1:0] rd_dl_ff;
   logic                 mem_we;
   logic [SLOT_BITS-1:0] mem_waddr;
   logic [TIME_BITS-1:0] mem_wdata;
   logic                 rd_en;
   logic [SLOT_BITS-1:0] rd_addr;

   logic                 out_free;
   logic                 can_push;
   logic                 push_req;
   rsp_type              push_data;
   logic [SLOT_BITS-1:0] cur_slot;
   logic [SLOT_BITS-1:0] ahead_slot;
   logic [TIME_BITS-1:0] cur_deadline;
   logic [TIME_BITS-1:0] age;
   logic                 due;
   logic [TIME_BITS-1:0] new_deadline;
   logic [SEQ_BITS-1:0]  ack_off;
   logic [SEQ_BITS-1:0]  scan_seq;
   logic [SEQ_BITS-1:0]  ahead_seq;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign q_pop     = (state_ff == ST_IDLE) & ~q_stat.empty;

   // Per-slot datapath: deadline check for the scan, targets for the slide.
   assign out_free     = ~out_valid_ff | ~rsp_stall;
   assign can_push     = ~pend_valid_ff | out_free;
   assign cur_slot     = slot_of(head_ff, k_ff);
   assign ahead_slot   = slot_of(head_ff, CNT_BITS'(WINDOW));
   assign cur_deadline = rd_vld_ff ? rd_dl_ff : '0;
   assign age          = tick_ff - cur_deadline;
   assign due          = ~acked_ff[cur_slot] & ~age[TIME_BITS-1];
   assign new_deadline = tick_ff + TIME_BITS'(timeout);
   assign ack_off      = SEQ_BITS'(q_rdata.ack) - base_ff;
   assign scan_seq     = base_ff + SEQ_BITS'(k_ff);
   assign ahead_seq    = base_ff + SEQ_BITS'(WINDOW);

   // Sequencer: one window slot per cycle unless a result cannot be staged; results are
   // staged through a pending register so the final one of a run can be marked.
   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      acked_in      = acked_ff;
      dl_valid_in   = dl_valid_ff;
      base_in       = base_ff;
      head_in       = head_ff;
      tick_in       = tick_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      rd_vld_in     = rd_vld_ff;
      mem_we        = 1'b0;
      mem_waddr     = cur_slot;
      mem_wdata     = new_deadline;
      rd_en         = 1'b0;
      rd_addr       = head_ff;
      push_req      = 1'b0;
      push_data     = '0;

      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_stat.empty) begin
               k_in = '0;
               if (q_rdata.kind == CMD_TICK) begin
                  // Advance time and fetch the oldest slot's deadline.
                  tick_in  = tick_ff + 1'b1;
                  rd_en    = 1'b1;
                  rd_addr  = head_ff;
                  state_in = ST_SCAN;
               end else if (ack_off < SEQ_BITS'(WINDOW)) begin
                  acked_in[slot_of(head_ff, CNT_BITS'(ack_off))] = 1'b1;
                  state_in = ST_SLIDE;
               end
            end
         end
         ST_SCAN: begin
            if (due && can_push) begin
               push_req              = 1'b1;
               push_data.send_number = 16'(scan_seq);
               push_data.is_resend   = 1'b1;
               mem_we                = 1'b1;
               mem_waddr             = cur_slot;
               dl_valid_in[cur_slot] = 1'b1;
            end
            if (!due || can_push) begin
               if (k_ff == CNT_BITS'(WINDOW - 1)) begin
                  state_in = ST_FINISH;
               end else begin
                  k_in    = k_ff + 1'b1;
                  rd_en   = 1'b1;
                  rd_addr = slot_of(head_ff, k_ff + 1'b1);
               end
            end
         end
         ST_SLIDE: begin
            if (k_ff != CNT_BITS'(WINDOW) && acked_ff[head_ff]) begin
               if (can_push) begin
                  // Release the packet one window ahead and arm its deadline.
                  push_req                = 1'b1;
                  push_data.send_number   = 16'(ahead_seq);
                  push_data.is_resend     = 1'b0;
                  acked_in[ahead_slot]    = 1'b0;
                  mem_we                  = 1'b1;
                  mem_waddr               = ahead_slot;
                  dl_valid_in[ahead_slot] = 1'b1;
                  base_in                 = base_ff + 1'b1;
                  head_in = (head_ff == SLOT_BITS'(SLOTS - 1)) ? '0 : head_ff + 1'b1;
                  k_in    = k_ff + 1'b1;
               end
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Flush the staged result as the last of its run.
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               out_in             = pend_ff;
               out_in.last_of_run = 1'b1;
               out_valid_in       = 1'b1;
               pend_valid_in      = 1'b0;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // A new result moves the staged one out, not marked as last.
      if (push_req) begin
         if (pend_valid_ff) begin
            out_in             = pend_ff;
            out_in.last_of_run = 1'b0;
            out_valid_in       = 1'b1;
         end
         pend_in       = push_data;
         pend_valid_in = 1'b1;
      end

      if (rd_en) begin
         rd_vld_in = dl_valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         acked_ff      <= '0;
         dl_valid_ff   <= '0;
         base_ff       <= '0;
         head_ff       <= '0;
         tick_ff       <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         acked_ff      <= acked_in;
         dl_valid_ff   <= dl_valid_in;
         base_ff       <= base_in;
         head_ff       <= head_in;
         tick_ff       <= tick_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      k_ff      <= k_in;
      pend_ff   <= pend_in;
      out_ff    <= out_in;
      rd_vld_ff <= rd_vld_in;
   end

   // Deadline memory: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         dl_mem_ff[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_dl_ff <= dl_mem_ff[rd_addr];
      end
   end

endmodule

/* rtl/selective_repeat_sender.sv */
// Selective-repeat ARQ sender.
// Each request is a timer tick or an acknowledgment number. A tick re-sends
// every unacknowledged packet of the window whose deadline has come; an
// acknowledgment inside the window marks its packet and slides the window
// over the acknowledged prefix, releasing one new packet per slide.
// Requests enter on req_valid/req_stall, are decoded into a two-entry
// command queue and carried out by the back end one at a time. Results
// leave on rsp_valid/rsp_stall in slot order, with last_of_run set on the
// final result of each request; a request may give no result at all.
// A tick scans the window in the back end, one window slot per cycle through
// the deadline memory's read port unless a due result has to wait; an
// in-window acknowledgment slides the window and any other one is dropped.
// A stalled receiver holds the output register; the back end then pauses
// with one more result staged, and the queue keeps taking requests until
// it fills. The retransmit timeout sits at byte address 0 of the register port.
// Synchronous reset clears the window, the time and the deadline valid bits, so
// deadlines read as zero, and loads the timeout with 4; no clearing pass is needed.
// Depends on srs_pkg, srs_front, srs_queue and srs_back.
module selective_repeat_sender import srs_pkg::*; #(
   parameter int WINDOW    = 8,
   parameter int SEQ_BITS  = 16,
   parameter int TIME_BITS = 32
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  req_type                  req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output rsp_type                  rsp_data,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]              pwdata,
   output logic [31:0]              prdata,
   output logic                     pready
);

   logic [7:0]     timeout_ff, timeout_in;
   logic           csr_write;
   logic           q_push;
   logic           q_pop;
   cmd_type        q_wdata;
   cmd_type        q_rdata;
   queue_stat_type q_stat;

   // Register port: always ready, one timeout register.
   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready
                    & (paddr[CSR_ADDR_BITS-1] == REG_TIMEOUT);
   assign prdata    = (paddr[CSR_ADDR_BITS-1] == REG_TIMEOUT) ? {24'd0, timeout_ff} : '0;
   assign timeout_in = csr_write ? pwdata[7:0] : timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   srs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_wdata   (q_wdata)
   );

   srs_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .stat  (q_stat)
   );

   srs_back #(
      .WINDOW    (WINDOW),
      .SEQ_BITS  (SEQ_BITS),
      .TIME_BITS (TIME_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .timeout   (timeout_ff),
      .q_stat    (q_stat),
      .q_rdata   (q_rdata),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* verif/srs_send_checker.sv */
// Checker of the selective-repeat sender: watches the request, result and
// register channels, predicts every send and compares it with each result.
// Depends on srs_pkg only.
module srs_send_checker import srs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  req_type                  req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  rsp_type                  rsp_data,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic                     pready,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [31:0]              pwdata,
   output int                       error_count,
   output int                       pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int         WINDOW      = 8;
   localparam int         SLOTS       = 2 * WINDOW;
   localparam logic [3:0] WINDOW_STEP = 4'd8;

   // Shadow of the sender's state. The slots form a ring of twice the window,
   // and head is the slot that holds the oldest packet of the window.
   logic        slot_done [SLOTS];
   logic [31:0] slot_due  [SLOTS];
   logic [15:0] base_seq;
   logic [3:0]  head;
   logic [31:0] now;
   logic [7:0]  resend_delay;

   // Sends predicted from accepted requests and not yet seen on the output.
   rsp_type expected_sends [$];
   int      mismatches = 0;

   // Works out the sends that one request causes and updates the shadow state.
   task automatic predict_sends(input req_type request);
      rsp_type     run [WINDOW];
      rsp_type     item;
      int          n;
      int          k;
      logic [3:0]  slot;
      logic [15:0] offset;
      logic [31:0] age;
      n = 0;
      if (request.operation == OP_TICK) begin
         // A tick re-sends every unacknowledged packet whose deadline has come.
         now = now + 32'd1;
         for (k = 0; k < WINDOW; k++) begin
            slot = head + 4'(k);
            age  = now - slot_due[slot];
            if (!slot_done[slot] && !age[31]) begin
               slot_due[slot]   = now + {24'd0, resend_delay};
               item.send_number = base_seq + 16'(k);
               item.is_resend   = 1'b1;
               item.last_of_run = 1'b0;
               run[n]           = item;
               n++;
            end
         end
      end else begin
         // An acknowledgment inside the window marks its packet, then the
         // window slides over the acknowledged prefix.
         offset = request.ack_number - base_seq;
         if (offset < WINDOW) begin
            slot            = head + offset[3:0];
            slot_done[slot] = 1'b1;
            for (k = 0; k < WINDOW && slot_done[head]; k++) begin
               slot             = head + WINDOW_STEP;
               slot_done[slot]  = 1'b0;
               slot_due[slot]   = now + {24'd0, resend_delay};
               item.send_number = base_seq + 16'(WINDOW);
               item.is_resend   = 1'b0;
               item.last_of_run = 1'b0;
               run[n]           = item;
               n++;
               base_seq = base_seq + 16'd1;
               head     = head + 4'd1;
            end
         end
      end
      // The final send of the request carries the end-of-run mark.
      for (k = 0; k < n; k++) begin
         item = run[k];
         item.last_of_run = (k == n - 1);
         expected_sends.push_back(item);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      int      i;
      if (reset) begin
         for (i = 0; i < SLOTS; i++) begin
            slot_done[i] = 1'b0;
            slot_due[i]  = '0;
         end
         base_seq     = '0;
         head         = '0;
         now          = '0;
         resend_delay = TIMEOUT_RESET;
         expected_sends.delete();
      end else begin
         // Register writes; writes to addresses beyond the map are ignored.
         if (psel && penable && pwrite && pready &&
             paddr[CSR_ADDR_BITS-1:2] == REG_TIMEOUT) begin
            resend_delay = pwdata[7:0];
         end

         if (req_valid && !req_stall) begin
            predict_sends(req_data);
         end

         // Each result is compared with the oldest prediction.
         if (rsp_valid && !rsp_stall) begin
            if (expected_sends.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected send: expected none, actual number %h resend %b last %b",
                        $time, rsp_data.send_number, rsp_data.is_resend,
                        rsp_data.last_of_run);
            end else begin
               want = expected_sends.pop_front();
               if (want != rsp_data) begin
                  mismatches++;
               end
               if (want.send_number != rsp_data.send_number) begin
                  $display("%0t: send_number mismatch: expected %h, actual %h",
                           $time, want.send_number, rsp_data.send_number);
               end
               if (want.is_resend != rsp_data.is_resend) begin
                  $display("%0t: is_resend mismatch on send %h: expected %b, actual %b",
                           $time, want.send_number, want.is_resend, rsp_data.is_resend);
               end
               if (want.last_of_run != rsp_data.last_of_run) begin
                  $display("%0t: last_of_run mismatch on send %h: expected %b, actual %b",
                           $time, want.send_number, want.last_of_run,
                           rsp_data.last_of_run);
               end
            end
         end
      end
      error_count   <= mismatches;
      pending_count <= expected_sends.size();
   end

endmodule

/* verif/testbench.sv */
// Top of the selective-repeat sender testbench: clock, reset, requests,
// register writes and the verdict. Depends on srs_pkg, the block and the
// checker module srs_send_checker.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import srs_pkg::*;

   localparam logic [CSR_ADDR_BITS-1:0] TIMEOUT_ADDR  = {REG_TIMEOUT, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] SPARE_ADDR    = {~REG_TIMEOUT, 2'b00};
   localparam int                       SETTLE_CYCLES = 48;
   localparam int                       PHASE_ITEMS   = 55;

   logic                     clock;
   logic                     reset     = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   req_type                  req_data  = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   rsp_type                  rsp_data;
   logic                     psel      = 1'b0;
   logic                     penable   = 1'b0;
   logic                     pwrite    = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr     = '0;
   logic [31:0]              pwdata    = '0;
   logic [31:0]              prdata;
   logic                     pready;

   int          error_count;
   int          pending_count;
   int          idle_percent  = 0;
   int          stall_percent = 0;
   int          ticks_sent    = 0;
   int          acks_sent     = 0;
   int          results_seen  = 0;
   int          resends_seen  = 0;
   logic [15:0] window_guess  = '0;

   selective_repeat_sender u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   srs_send_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .pready       (pready),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .error_count  (error_count),
      .pending_count(pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The receiver stalls at random with the current percentage.
   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(0, 99) < stall_percent);
   end

   // Track the window from the new packets released, so that most random
   // acknowledgments land inside it. Results are also counted here.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (rsp_data.is_resend) begin
            resends_seen++;
         end else begin
            window_guess <= rsp_data.send_number - 16'd7;
         end
      end
   end

   // Offers one request, after a random number of idle cycles, and returns at
   // the edge where it is accepted. Valid stays high for a following request.
   task automatic send_request(input logic op, input logic [15:0] number);
      req_type request;
      request.operation  = op;
      request.ack_number = number;
      while ($urandom_range(0, 99) < idle_percent) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_data  <= request;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (op == OP_TICK) begin
         ticks_sent++;
      end else begin
         acks_sent++;
      end
   endtask

   // One register write: the setup phase, then the access phase until pready.
   task automatic write_register(input logic [CSR_ADDR_BITS-1:0] addr,
                                 input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= addr;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   // Stops offering requests, waits for every predicted send, then lets a
   // request that sends nothing finish inside the block.
   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Random requests: ticks, acknowledgments near the window, and noise.
   task automatic random_requests(input int count);
      int i;
      int pick;
      for (i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            send_request(OP_TICK, 16'($urandom));
         end else if (pick < 85) begin
            send_request(OP_ACK, window_guess + 16'($urandom_range(0, 9)));
         end else begin
            send_request(OP_ACK, 16'($urandom));
         end
      end
   endtask

   initial begin
      int         phase;
      logic [7:0] delay;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Acknowledgments outside the window, including one that wraps below it.
      send_request(OP_ACK, 16'hFFFF);
      send_request(OP_ACK, 16'd8);
      // The first tick sends the whole window as resends.
      send_request(OP_TICK, 16'hFFFF);
      send_request(OP_TICK, 16'h0000);
      // A mark without a slide, repeated, then two slides of one packet each.
      send_request(OP_ACK, 16'd3);
      send_request(OP_ACK, 16'd3);
      send_request(OP_ACK, 16'd0);
      send_request(OP_ACK, 16'd1);
      // An acknowledgment that slides over two packets, then the newest slot.
      send_request(OP_ACK, 16'd2);
      send_request(OP_ACK, 16'd11);
      send_request(OP_ACK, 16'hAAAA);
      send_request(OP_ACK, 16'h5555);
      // Ticks until the deadlines armed by the first tick come due.
      repeat (3) send_request(OP_TICK, 16'h0000);
      drain;

      // A zero timeout makes every re-sent packet due again on each later tick.
      write_register(TIMEOUT_ADDR, 32'd0);
      repeat (2) send_request(OP_TICK, 16'h0000);
      drain;
      // A write beyond the register map must change nothing.
      write_register(SPARE_ADDR, 32'hFFFF_FFFF);
      send_request(OP_TICK, 16'h0000);
      drain;
      write_register(TIMEOUT_ADDR, 32'd255);
      repeat (2) send_request(OP_TICK, 16'h0000);
      drain;

      // Random phases: two timeout settings under each flow-control mix.
      for (phase = 0; phase < 6; phase++) begin
         case (phase / 2)
            0: begin
               idle_percent  = 16;
               stall_percent = 77;
            end
            1: begin
               idle_percent  = 77;
               stall_percent = 16;
            end
            default: begin
               idle_percent  = 0;
               stall_percent = 0;
            end
         endcase
         case (phase)
            0: delay = 8'd255;
            1: delay = 8'($urandom_range(1, 255));
            2: delay = 8'd1;
            3: delay = 8'($urandom_range(2, 12));
            4: delay = TIMEOUT_RESET;
            default: delay = 8'($urandom_range(1, 255));
         endcase
         write_register(TIMEOUT_ADDR, {24'd0, delay});
         random_requests(PHASE_ITEMS);
         drain;
      end

      $display("Sent %0d ticks and %0d acknowledgments under seven timeout settings",
               ticks_sent, acks_sent);
      $display("and three flow-control mixes; checked %0d sends, %0d of them resends.",
               results_seen, resends_seen);
      if (error_count == 0 && pending_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #4_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

/* selective_repeat_sender.f */
rtl/srs_pkg.sv
rtl/srs_front.sv
rtl/srs_queue.sv
rtl/srs_back.sv
rtl/selective_repeat_sender.sv
verif/srs_send_checker.sv
verif/testbench.sv
